>>> rtl/tgapd_pkg.sv
// Package for the TGA pixel stream decoder.
// Holds register indexes, pixel format codes and the result item type.
// No dependencies.
`timescale 1ns / 1ps

package tgapd_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_RLE_MODE     = 2'd0;
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

  // Pixel format codes; the fourth code is unsupported
  localparam logic [1:0] FMT_RGB555      = 2'd0;
  localparam logic [1:0] FMT_BGR24       = 2'd1;
  localparam logic [1:0] FMT_BGRA32      = 2'd2;
  localparam logic [1:0] FMT_UNSUPPORTED = 2'd3;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned PixCountWidth = 32;

  // One decoded result item
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    logic       format_error;
  } pix_t;

endpackage

>>> rtl/tgapd_if.sv
// Stream interfaces of the TGA pixel stream decoder.
// tgapd_byte_if carries image data bytes, tgapd_pix_if carries decoded pixels.
// No dependencies.
`timescale 1ns / 1ps

interface tgapd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tgapd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_count;
  logic       last_pixel;
  logic       format_error;

  modport source (
    output valid, output red, output green, output blue, output alpha,
    output repeat_count, output last_pixel, output format_error, input ready
  );
  modport sink (
    input valid, input red, input green, input blue, input alpha,
    input repeat_count, input last_pixel, input format_error, output ready
  );
endinterface

>>> rtl/tga_pixel_stream_decoder_top.sv
// Top level of the TGA pixel stream decoder.
// Depends on tgapd_pkg and the stream interfaces in tgapd_if.sv.
`timescale 1ns / 1ps

// Usage:
//   in_i carries the bytes of the TGA image data section, one byte per item.
//   out_o carries decoded pixels (RGBA plus a repeat count for RLE runs),
//   at most one item per input byte; bytes that only gather a pixel or hold
//   an RLE packet header produce no item.
//   The header values (RLE, pixel format, width, height) are written over the
//   cfg port while no item is in flight; width times height is multiplied at
//   the write, so the next cycle may already carry data.
//   Output: a pixel is registered and appears on out_o in the cycle after its last byte is taken.
//   Throughput: one byte per cycle. The byte is decoded by short logic into a
//   single output register; in_i stays ready while that register is empty or
//   being drained, so a byte is taken even while a result is being handed over.
//   When the receiver stalls, the result holds and in_i drops ready until the
//   result is taken.
//   Reset clears the packet state and the pixel count and loads the register
//   defaults (no RLE, 24-bit, zero size). An unsupported format reports one
//   error item and then drops all bytes until reset.
module tga_pixel_stream_decoder_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [tgapd_pkg::CfgDataWidth-1:0]   cfg_data_i,
  tgapd_byte_if.sink                           in_i,
  tgapd_pix_if.source                          out_o
);

  localparam int unsigned CntW = tgapd_pkg::PixCountWidth;

  // Configuration registers
  logic        rle_q;
  logic [1:0]  fmt_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [CntW-1:0] total_q;

  // Decode state
  logic            hdr_q, hdr_d;
  logic            run_q, run_d;
  logic [7:0]      left_q, left_d;
  logic [1:0]      phase_q, phase_d;
  logic [23:0]     gath_q, gath_d;
  logic [CntW-1:0] done_q, done_d;
  logic            fin_q, fin_d;
  logic            err_q, err_d;

  // Output register
  logic              out_valid_q;
  tgapd_pkg::pix_t   out_q;
  tgapd_pkg::pix_t   res;
  logic              res_valid;

  logic        acc;
  logic [15:0] mul_a, mul_b;
  logic        fmt_bad;
  logic [2:0]  bpp;
  logic [CntW-1:0] remain;
  logic [7:0]  rep;
  logic [7:0]  rep_clamp;
  logic [7:0]  r_c, g_c, b_c, a_c;
  logic [15:0] w555;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  // Pixel total follows the size registers at the write edge
  assign mul_a = (cfg_we_i && cfg_idx_i == tgapd_pkg::REG_IMAGE_WIDTH)  ? cfg_data_i : width_q;
  assign mul_b = (cfg_we_i && cfg_idx_i == tgapd_pkg::REG_IMAGE_HEIGHT) ? cfg_data_i : height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_q    <= 1'b0;
      fmt_q    <= tgapd_pkg::FMT_BGR24;
      width_q  <= '0;
      height_q <= '0;
      total_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tgapd_pkg::REG_RLE_MODE:     rle_q    <= cfg_data_i[0];
        tgapd_pkg::REG_PIXEL_FORMAT: fmt_q    <= cfg_data_i[1:0];
        tgapd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        tgapd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
      total_q <= CntW'({16'd0, mul_a} * {16'd0, mul_b});
    end
  end

  assign fmt_bad = (fmt_q == tgapd_pkg::FMT_UNSUPPORTED)
                   || (rle_q && fmt_q == tgapd_pkg::FMT_RGB555);

  always_comb begin
    unique case (fmt_q)
      tgapd_pkg::FMT_RGB555: bpp = 3'd2;
      tgapd_pkg::FMT_BGR24:  bpp = 3'd3;
      default:               bpp = 3'd4;
    endcase
  end

  assign remain = total_q - done_q;
  assign w555   = {in_i.data_byte, gath_q[7:0]};

  // Assemble colors from the gathered bytes and the closing byte
  always_comb begin
    a_c = 8'd0;
    b_c = gath_q[7:0];
    g_c = gath_q[15:8];
    r_c = gath_q[23:16];
    priority if (fmt_q == tgapd_pkg::FMT_RGB555) begin
      b_c = {w555[4:0], 3'b000};
      g_c = {w555[9:5], 3'b000};
      r_c = {w555[14:10], 3'b000};
    end else if (bpp == 3'd3 && phase_q == 2'd2) begin
      r_c = in_i.data_byte;
    end else if (phase_q == 2'd3) begin
      a_c = in_i.data_byte;
    end else begin
      // pixel cut short by a format change: close with this byte
      unique case (phase_q)
        2'd1:    g_c = in_i.data_byte;
        2'd2:    r_c = in_i.data_byte;
        default: b_c = in_i.data_byte;
      endcase
    end
  end

  // Advance packet and pixel state for one accepted item
  always_comb begin
    hdr_d     = hdr_q;
    run_d     = run_q;
    left_d    = left_q;
    phase_d   = phase_q;
    gath_d    = gath_q;
    done_d    = done_q;
    fin_d     = fin_q;
    err_d     = err_q;
    res_valid = 1'b0;
    res       = '0;
    rep       = 8'd1;
    rep_clamp = 8'd1;
    if (acc) begin
      priority if (err_q) begin
        // drop everything after an error
      end else if (fmt_bad) begin
        err_d            = 1'b1;
        res_valid        = 1'b1;
        res.format_error = 1'b1;
      end else if (fin_q || done_q >= total_q) begin
        fin_d = 1'b1;
      end else if (rle_q && hdr_q) begin
        run_d   = in_i.data_byte[7];
        left_d  = {1'b0, in_i.data_byte[6:0]} + 8'd1;
        hdr_d   = 1'b0;
        phase_d = 2'd0;
        gath_d  = '0;
      end else if ({1'b0, phase_q} + 3'd1 < bpp) begin
        unique case (phase_q)
          2'd0:    gath_d[7:0]   = gath_q[7:0]   | in_i.data_byte;
          2'd1:    gath_d[15:8]  = gath_q[15:8]  | in_i.data_byte;
          2'd2:    gath_d[23:16] = gath_q[23:16] | in_i.data_byte;
          default: ;
        endcase
        phase_d = phase_q + 2'd1;
      end else begin
        phase_d = 2'd0;
        gath_d  = '0;
        if (rle_q) begin
          if (run_q) begin
            rep    = (left_q == 8'd0) ? 8'd1 : left_q;
            left_d = 8'd0;
          end else if (left_q != 8'd0) begin
            left_d = left_q - 8'd1;
          end
          if (left_d == 8'd0) hdr_d = 1'b1;
        end
        rep_clamp = (remain < {{(CntW-8){1'b0}}, rep}) ? remain[7:0] : rep;
        done_d    = done_q + {{(CntW-8){1'b0}}, rep_clamp};
        if (done_d >= total_q) fin_d = 1'b1;
        res_valid        = 1'b1;
        res.red          = r_c;
        res.green        = g_c;
        res.blue         = b_c;
        res.alpha        = a_c;
        res.repeat_count = rep_clamp;
        res.last_pixel   = fin_d;
      end
    end
  end

  // Hold decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= 1'b1;
      run_q   <= 1'b0;
      left_q  <= '0;
      phase_q <= '0;
      gath_q  <= '0;
      done_q  <= '0;
      fin_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      hdr_q   <= hdr_d;
      run_q   <= run_d;
      left_q  <= left_d;
      phase_q <= phase_d;
      gath_q  <= gath_d;
      done_q  <= done_d;
      fin_q   <= fin_d;
      err_q   <= err_d;
    end
  end

  // Load a new result or drain the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.red          = out_q.red;
  assign out_o.green        = out_q.green;
  assign out_o.blue         = out_q.blue;
  assign out_o.alpha        = out_q.alpha;
  assign out_o.repeat_count = out_q.repeat_count;
  assign out_o.last_pixel   = out_q.last_pixel;
  assign out_o.format_error = out_q.format_error;

endmodule

>>> rtl/tgapd_checker.sv
// Port-level checks for the TGA pixel stream decoder.
// Bound to tga_pixel_stream_decoder_top; uses only its ports.
`timescale 1ns / 1ps

module tgapd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i,
  input logic [7:0] repeat_count_i,
  input logic       last_pixel_i,
  input logic       format_error_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_i) && $stable(green_i)
      && $stable(blue_i) && $stable(alpha_i) && $stable(repeat_count_i))
    else $error("stalled result changed");

  // An error item carries nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && format_error_i |-> red_i == 8'd0 && green_i == 8'd0 && blue_i == 8'd0
      && alpha_i == 8'd0 && repeat_count_i == 8'd0 && !last_pixel_i)
    else $error("error item with payload");

  // A pixel always covers at least one position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !format_error_i |-> repeat_count_i != 8'd0)
    else $error("pixel with zero repeat count");

  // Nothing follows a taken error item until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && format_error_i |=> !out_valid_i)
    else $error("item after format error");

endmodule

bind tga_pixel_stream_decoder_top tgapd_checker u_tgapd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .red_i          (out_o.red),
  .green_i        (out_o.green),
  .blue_i         (out_o.blue),
  .alpha_i        (out_o.alpha),
  .repeat_count_i (out_o.repeat_count),
  .last_pixel_i   (out_o.last_pixel),
  .format_error_i (out_o.format_error)
);

>>> sim/testbench.sv
// Testbench for the TGA pixel stream decoder: streams image data bytes under
// changing header registers, predicts every decoded pixel and checks the output.
// Depends on tgapd_pkg, the stream interfaces and tga_pixel_stream_decoder_top.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_BYTES = 37;

  typedef enum logic [2:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH,
    IDLE_PRESSURE
  } idle_mode_e;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b1;
  logic                               cfg_we_i = 1'b0;
  logic [1:0]                         cfg_idx_i = tgapd_pkg::REG_RLE_MODE;
  logic [tgapd_pkg::CfgDataWidth-1:0] cfg_data_i = '0;

  tgapd_byte_if in_if ();
  tgapd_pix_if  out_if ();

  tga_pixel_stream_decoder_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Pending image bytes and the pixels they must produce
  logic [7:0]      byte_q[$];
  tgapd_pkg::pix_t pix_expected[$];
  idle_mode_e      idle_mode = IDLE_NONE;
  int unsigned     mismatch_cnt = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     hold_cnt = 0;

  // Header register copies
  logic        cfg_rle = 1'b0;
  logic [1:0]  cfg_fmt = tgapd_pkg::FMT_BGR24;
  logic [15:0] cfg_w = '0;
  logic [15:0] cfg_h = '0;

  // Decoder state copy
  logic        hdr_pending = 1'b1;
  logic        run_packet = 1'b0;
  logic [7:0]  pkt_remaining = '0;
  logic [1:0]  phase_cnt = '0;
  logic [23:0] gathered = '0;
  logic [31:0] pix_count = '0;
  logic        img_done = 1'b0;
  logic        err_sent = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned pixel_bytes(input logic [1:0] fmt);
    if (fmt == tgapd_pkg::FMT_RGB555) return 2;
    if (fmt == tgapd_pkg::FMT_BGR24) return 3;
    return 4;
  endfunction

  // Advance the decoder copy by one byte and queue the pixel it completes
  task automatic decode_byte(input logic [7:0] b);
    logic [31:0]     total;
    logic [31:0]     rep;
    logic [15:0]     w555;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    int unsigned     bpp;
    tgapd_pkg::pix_t px;
    total = {16'd0, cfg_w} * {16'd0, cfg_h};
    px = '0;
    if (err_sent) return;
    if (cfg_fmt == tgapd_pkg::FMT_UNSUPPORTED
        || (cfg_rle && cfg_fmt == tgapd_pkg::FMT_RGB555)) begin
      err_sent = 1'b1;
      px.format_error = 1'b1;
      pix_expected.push_back(px);
      return;
    end
    if (img_done || pix_count >= total) begin
      img_done = 1'b1;
      return;
    end
    // Packet header: open a raw or run packet
    if (cfg_rle && hdr_pending) begin
      run_packet = b[7];
      pkt_remaining = {1'b0, b[6:0]} + 8'd1;
      hdr_pending = 1'b0;
      phase_cnt = '0;
      gathered = '0;
      return;
    end
    bpp = pixel_bytes(cfg_fmt);
    if (phase_cnt + 1 < bpp) begin
      gathered = 24'({8'd0, gathered} | ({24'd0, b} << (8 * phase_cnt)));
      phase_cnt = phase_cnt + 2'd1;
      return;
    end

    // Last byte of the pixel
    alpha = '0;
    if (cfg_fmt == tgapd_pkg::FMT_RGB555) begin
      w555 = {b, gathered[7:0]};
      blue = {w555[4:0], 3'b000};
      green = {w555[9:5], 3'b000};
      red = {w555[14:10], 3'b000};
    end else if (bpp == 3 && phase_cnt == 2'd2) begin
      blue = gathered[7:0];
      green = gathered[15:8];
      red = b;
    end else if (phase_cnt == 2'd3) begin
      blue = gathered[7:0];
      green = gathered[15:8];
      red = gathered[23:16];
      alpha = b;
    end else begin
      // Pixel cut short by a format change: the byte lands in its own slot
      blue = gathered[7:0];
      green = gathered[15:8];
      red = gathered[23:16];
      case (phase_cnt)
        2'd1:    green = b;
        2'd2:    red = b;
        default: blue = b;
      endcase
    end
    phase_cnt = '0;
    gathered = '0;

    rep = 1;
    if (cfg_rle) begin
      if (run_packet) begin
        rep = (pkt_remaining == 0) ? 32'd1 : {24'd0, pkt_remaining};
        pkt_remaining = '0;
      end else if (pkt_remaining != 0) begin
        pkt_remaining = pkt_remaining - 8'd1;
      end
      if (pkt_remaining == 0) hdr_pending = 1'b1;
    end
    // Clamp a run to the pixels still missing
    if (rep > total - pix_count) rep = total - pix_count;
    pix_count = pix_count + rep;
    if (pix_count >= total) img_done = 1'b1;

    px.red = red;
    px.green = green;
    px.blue = blue;
    px.alpha = alpha;
    px.repeat_count = rep[7:0];
    px.last_pixel = img_done;
    pix_expected.push_back(px);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t ns: %s expected 0x%02h, actual 0x%02h", $time, name, want, got);
    end
  endtask

  // Byte driver: offer the next pending item, predict each accepted one
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic offer;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
    end else begin
      if (in_if.valid && in_if.ready) decode_byte(in_if.data_byte);
      case (idle_mode)
        IDLE_SRC:  offer = ($urandom_range(0, 99) >= 76);
        IDLE_BOTH: offer = ($urandom_range(0, 99) >= 18);
        default:   offer = 1'b1;
      endcase
      if (!in_if.valid || in_if.ready) begin
        if (byte_q.size() != 0 && offer) begin
          in_if.valid <= 1'b1;
          in_if.data_byte <= byte_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: check each accepted item and drive ready
  always @(posedge clk_i or negedge rst_ni) begin : receive
    tgapd_pkg::pix_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pix_expected.size() == 0) begin
          mismatch_cnt++;
          $display("%0t ns: pixel expected none, actual rgba 0x%02h%02h%02h%02h error %b",
                   $time, out_if.red, out_if.green, out_if.blue, out_if.alpha,
                   out_if.format_error);
        end else begin
          want = pix_expected.pop_front();
          compare_field("red", want.red, out_if.red);
          compare_field("green", want.green, out_if.green);
          compare_field("blue", want.blue, out_if.blue);
          compare_field("alpha", want.alpha, out_if.alpha);
          compare_field("repeat_count", want.repeat_count, out_if.repeat_count);
          compare_field("last_pixel", 8'(want.last_pixel), 8'(out_if.last_pixel));
          compare_field("format_error", 8'(want.format_error), 8'(out_if.format_error));
        end
      end
      case (idle_mode)
        IDLE_SINK: out_if.ready <= ($urandom_range(0, 99) >= 76);
        IDLE_BOTH: out_if.ready <= ($urandom_range(0, 99) >= 18);
        IDLE_PRESSURE: begin
          // Hold off once for a long stretch so the decoder backs up
          if (hold_cnt < HOLD_CYCLES) begin
            out_if.ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tgapd_pkg::REG_RLE_MODE:     cfg_rle = data[0];
      tgapd_pkg::REG_PIXEL_FORMAT: cfg_fmt = data[1:0];
      tgapd_pkg::REG_IMAGE_WIDTH:  cfg_w = data;
      default:                     cfg_h = data;
    endcase
  endtask

  task automatic configure(input logic rle, input logic [1:0] fmt,
                           input logic [15:0] width, input logic [15:0] height);
    write_reg(tgapd_pkg::REG_RLE_MODE, {15'd0, rle});
    write_reg(tgapd_pkg::REG_PIXEL_FORMAT, {14'd0, fmt});
    write_reg(tgapd_pkg::REG_IMAGE_WIDTH, width);
    write_reg(tgapd_pkg::REG_IMAGE_HEIGHT, height);
  endtask

  // Wait until every byte is taken and every pixel has arrived
  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || in_if.valid || pix_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_word(input logic [63:0] word, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) byte_q.push_back(word[8*i +: 8]);
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) byte_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed packets with random colors, some stray bytes
  task automatic queue_random(input int unsigned n_bytes);
    int unsigned pushed;
    int unsigned bpp;
    int unsigned pick;
    int unsigned npix;
    pushed = 0;
    bpp = pixel_bytes(cfg_fmt);
    while (pushed < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (!cfg_rle || pick < 8) begin
        push_random(1);
        pushed += 1;
      end else if (pick < 54) begin
        byte_q.push_back(8'($urandom_range(128, 255)));
        push_random(bpp);
        pushed += 1 + bpp;
      end else begin
        npix = (pick < 58) ? $urandom_range(6, 24) : $urandom_range(1, 5);
        byte_q.push_back(8'(npix - 1));
        push_random(npix * bpp);
        pushed += 1 + npix * bpp;
      end
    end
  endtask

  initial begin
    int unsigned fill;
    int unsigned k;
    int unsigned h;
    int unsigned w;
    int unsigned bpp;
    logic [1:0]  fmt;
    logic [15:0] width;
    logic [15:0] height;

    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 24-bit extremes, then a 32-bit pixel
    configure(1'b0, tgapd_pkg::FMT_BGR24, 16'hffff, 16'hffff);
    queue_word(64'h0000_ffff_ff00_0000, 6);
    wait_idle();
    write_reg(tgapd_pkg::REG_PIXEL_FORMAT, {14'd0, tgapd_pkg::FMT_BGRA32});
    queue_word(64'h0000_0000_ff00_ff00, 4);
    wait_idle();
    // Switch to 24-bit with three bytes gathered: the next byte closes the pixel
    queue_word(64'h0000_0000_00c3_b2a1, 3);
    wait_idle();
    write_reg(tgapd_pkg::REG_PIXEL_FORMAT, {14'd0, tgapd_pkg::FMT_BGR24});
    queue_word(64'h0000_0000_0000_00d4, 1);
    wait_idle();
    // 16-bit words with all fields high, then only the unused top bit
    write_reg(tgapd_pkg::REG_PIXEL_FORMAT, {14'd0, tgapd_pkg::FMT_RGB555});
    queue_word(64'h0000_0000_8000_7fff, 4);
    wait_idle();
    // RLE: one raw pixel, then a full-length run
    configure(1'b1, tgapd_pkg::FMT_BGR24, 16'hffff, 16'hffff);
    queue_word(64'h6655_44ff_3322_1100, 8);
    wait_idle();

    // Random phases, alternating raw and RLE data under the none, source, sink and both idling patterns
    for (int m = 0; m < 4; m++) begin
      for (int rle = 0; rle < 2; rle++) begin
        idle_mode = idle_mode_e'(m);
        fmt = ($urandom_range(0, 1) != 0) ? tgapd_pkg::FMT_BGRA32 : tgapd_pkg::FMT_BGR24;
        if (rle == 0 && $urandom_range(0, 2) == 0) fmt = tgapd_pkg::FMT_RGB555;
        width = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(4096, 65535));
        height = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(4096, 65535));
        configure(rle[0], fmt, width, height);
        queue_random(PHASE_BYTES);
        wait_idle();
      end
    end

    // Receiver holds off while bytes keep coming
    idle_mode = IDLE_PRESSURE;
    configure(1'b0, tgapd_pkg::FMT_RGB555, 16'hffff, 16'hffff);
    queue_random(PHASE_BYTES);
    wait_idle();

    // Close any open RLE packet so the next byte is a header
    idle_mode = IDLE_BOTH;
    write_reg(tgapd_pkg::REG_RLE_MODE, 16'd1);
    write_reg(tgapd_pkg::REG_PIXEL_FORMAT, {14'd0, tgapd_pkg::FMT_BGR24});
    if (!hdr_pending) begin
      bpp = pixel_bytes(tgapd_pkg::FMT_BGR24);
      fill = (phase_cnt + 1 >= bpp) ? 1 : bpp - phase_cnt;
      if (!run_packet) fill += (pkt_remaining - 1) * bpp;
      push_random(fill);
      wait_idle();
    end

    // Shrink the image to a few pixels past the count: a full run overshoots
    k = $urandom_range(2, 20);
    h = pix_count / 65535 + 1;
    w = (pix_count + k + h - 1) / h;
    write_reg(tgapd_pkg::REG_IMAGE_WIDTH, 16'(w));
    write_reg(tgapd_pkg::REG_IMAGE_HEIGHT, 16'(h));
    queue_word(64'h0000_0000_c080_40ff, 4);
    push_random(12);
    wait_idle();

    // Zero size: everything is dropped
    configure(1'b0, tgapd_pkg::FMT_BGRA32, 16'd0, 16'd0);
    push_random(8);
    wait_idle();

    // RLE with 16-bit pixels: one error item, then silence
    configure(1'b1, tgapd_pkg::FMT_RGB555, 16'hffff, 16'hffff);
    push_random(6);
    wait_idle();
    write_reg(tgapd_pkg::REG_RLE_MODE, 16'd0);
    write_reg(tgapd_pkg::REG_PIXEL_FORMAT, {14'd0, tgapd_pkg::FMT_UNSUPPORTED});
    push_random(6);
    wait_idle();

    if (mismatch_cnt == 0 && pix_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
